[src/sorted_two_level_key_registry_defines.svh]
// Assertion macros shared by the registry RTL.
`ifndef SORTED_TWO_LEVEL_KEY_REGISTRY_DEFINES_SVH
`define SORTED_TWO_LEVEL_KEY_REGISTRY_DEFINES_SVH
// Implication checked on every rising edge of aclk, held off during reset.
`define SRKR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Plain property checked on every rising edge of aclk, held off during reset.
`define SRKR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`endif

[src/srkr_pkg.sv]
// Package: operation and status codes and the cell compare record.
package srkr_pkg;
    localparam logic [1:0] OP_ADD_TYPE  = 2'd0;
    localparam logic [1:0] OP_ADD_INST  = 2'd1;
    localparam logic [1:0] OP_FIND_TYPE = 2'd2;
    localparam logic [1:0] OP_FIND_INST = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_ZERO_ID = 3'd2;
    localparam logic [2:0] ST_NO_TYPE = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam int SCHEMA_W = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 7;
    localparam int ORDER_W  = 6;
    localparam int TCNT_W   = 6;
    localparam int ICNT_W   = 7;

    typedef struct packed {
        logic less;   // entry sorts below the search key
        logic bound;  // first entry not below the key (lower bound slot)
        logic hit;    // lower bound slot holds the key itself
    } srkr_cmp_t;
endpackage

[src/srkr_cell.sv]
// One sorted slot: compares against the search key and shifts up on insert.
module srkr_cell import srkr_pkg::*; #(
    parameter int HI_W   = 32,
    parameter int LO_W   = 32,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              valid,
    input  logic              insert,
    input  logic              prev_less,
    input  logic [HI_W-1:0]   prev_hi,
    input  logic [LO_W-1:0]   prev_lo,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [HI_W-1:0]   key_hi,
    input  logic [LO_W-1:0]   key_lo,
    input  logic [DATA_W-1:0] new_data,
    output logic [HI_W-1:0]   hi,
    output logic [LO_W-1:0]   lo,
    output logic [DATA_W-1:0] data,
    output srkr_cmp_t         cmp
);
    logic [HI_W-1:0]   hi_reg;
    logic [LO_W-1:0]   lo_reg;
    logic [DATA_W-1:0] data_reg;
    logic              eq;

    assign eq = (hi_reg == key_hi) && (lo_reg == key_lo);

    always_comb begin
        cmp.less  = valid && ((hi_reg < key_hi) || ((hi_reg == key_hi) && (lo_reg < key_lo)));
        cmp.bound = prev_less && !cmp.less;
        cmp.hit   = cmp.bound && valid && eq;
    end

    always_ff @(posedge aclk) begin
        if (insert && cmp.bound) begin
            hi_reg   <= key_hi;
            lo_reg   <= key_lo;
            data_reg <= new_data;
        end else if (insert && !prev_less) begin
            hi_reg   <= prev_hi;
            lo_reg   <= prev_lo;
            data_reg <= prev_data;
        end
    end

    assign hi   = hi_reg;
    assign lo   = lo_reg;
    assign data = data_reg;
endmodule

[src/sorted_two_level_key_registry.sv]
// Top level: sorted type and instance registries built as chains of cells.
//
// Input stream (s_): one request per transfer. s_tuser carries the operation
// (add type, add instance, find type, find instance), s_tdata the keys,
// schemas and handles. Output stream (m_): one result per request, s status
// in m_tuser, found flag, slot, stored fields and both fill counts in m_tdata.
// Every cell of a chain compares its key against the request in parallel;
// the first cell not below the key marks the lower-bound slot, and on an
// insert every larger entry moves one cell up in the same clock.
// A request is first captured, then compared and shifted while its result is
// loaded into the result register. The block takes no new request until the
// captured one has been executed into the result register.
// When the receiver stalls, the finished result holds in the output register
// and the captured next request waits until the register frees up.
// Reset (aresetn low, synchronous) empties both tables and zeroes the
// insertion counters; table contents are not cleared, only the fill counts.
module sorted_two_level_key_registry import srkr_pkg::*; #(
    parameter int TYPE_DEPTH     = 32,
    parameter int INSTANCE_DEPTH = 64,
    parameter int KEY_WIDTH      = 32,
    parameter int HANDLE_WIDTH   = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata: type_key, instance_key, node_schema, edge_schema,
    //          rebuild_present, graph_handle, context_handle, zero pad
    input  logic [((2*KEY_WIDTH+2*SCHEMA_W+1+2*HANDLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic [1:0]          s_tuser,   // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata: found, position, found_node_schema, found_edge_schema,
    //          found_rebuild, found_order, found_graph, found_context,
    //          types_held, instances_held, zero pad
    output logic [((1+POS_W+2*SCHEMA_W+1+ORDER_W+2*HANDLE_WIDTH+TCNT_W+ICNT_W+7)/8)*8-1:0]
                                m_tdata,
    output logic [STATUS_W-1:0] m_tuser    // status
);
    localparam int KW   = KEY_WIDTH;
    localparam int HW   = HANDLE_WIDTH;
    localparam int IN_W = ((2*KW+2*SCHEMA_W+1+2*HW+7)/8)*8;
    localparam int OUT_RAW = 1+POS_W+2*SCHEMA_W+1+ORDER_W+2*HW+TCNT_W+ICNT_W;
    localparam int OUT_W = ((OUT_RAW+7)/8)*8;
    localparam int TIX_W = $clog2(TYPE_DEPTH);
    localparam int IIX_W = $clog2(INSTANCE_DEPTH);
    localparam int TFL_W = $clog2(TYPE_DEPTH+1);
    localparam int IFL_W = $clog2(INSTANCE_DEPTH+1);
    localparam int TD_W  = 2*SCHEMA_W+1+TIX_W;
    localparam int ID_W  = 2*HW+IIX_W;

    // request fields
    logic [1:0]          op_reg;
    logic [KW-1:0]       tkey_reg, ikey_reg;
    logic [SCHEMA_W-1:0] node_reg, edge_reg;
    logic                reb_reg;
    logic [HW-1:0]       graph_reg, ctx_reg;
    logic                busy_reg;

    logic [TFL_W-1:0] tfill_reg, tfill_next;
    logic [IFL_W-1:0] ifill_reg, ifill_next;
    logic [TIX_W-1:0] torder_reg;
    logic [IIX_W-1:0] iorder_reg;

    logic out_valid_reg;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic found_reg, found_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SCHEMA_W-1:0] fnode_reg, fnode_next, fedge_reg, fedge_next;
    logic freb_reg, freb_next;
    logic [ORDER_W-1:0] ford_reg, ford_next;
    logic [HW-1:0] fgraph_reg, fgraph_next, fctx_reg, fctx_next;

    logic exec, ins_t, ins_i;

    assign s_tready = !busy_reg;
    assign exec = busy_reg && (!out_valid_reg || m_tready);

    // type chain
    srkr_cmp_t       tcmp  [TYPE_DEPTH];
    logic [KW-1:0]   thi   [TYPE_DEPTH];
    logic            tlo   [TYPE_DEPTH];
    logic [TD_W-1:0] tdat  [TYPE_DEPTH];
    logic [TD_W-1:0] tnew;
    assign tnew = {node_reg, edge_reg, reb_reg, torder_reg};

    for (genvar i = 0; i < TYPE_DEPTH; i++) begin : g_tcell
        logic pl;
        logic [KW-1:0] ph;
        logic pb;
        logic [TD_W-1:0] pd;
        if (i == 0) begin : g_first
            assign pl = 1'b1;
            assign ph = '0;
            assign pb = 1'b0;
            assign pd = '0;
        end else begin : g_rest
            assign pl = tcmp[i-1].less;
            assign ph = thi[i-1];
            assign pb = tlo[i-1];
            assign pd = tdat[i-1];
        end
        srkr_cell #(.HI_W(KW), .LO_W(1), .DATA_W(TD_W)) u_cell (
            .aclk(aclk), .valid(TFL_W'(i) < tfill_reg), .insert(ins_t),
            .prev_less(pl), .prev_hi(ph), .prev_lo(pb), .prev_data(pd),
            .key_hi(tkey_reg), .key_lo(1'b0), .new_data(tnew),
            .hi(thi[i]), .lo(tlo[i]), .data(tdat[i]), .cmp(tcmp[i])
        );
    end

    // instance chain
    srkr_cmp_t       icmp  [INSTANCE_DEPTH];
    logic [KW-1:0]   ihi   [INSTANCE_DEPTH];
    logic [KW-1:0]   ilo   [INSTANCE_DEPTH];
    logic [ID_W-1:0] idat  [INSTANCE_DEPTH];
    logic [ID_W-1:0] inew;
    assign inew = {graph_reg, ctx_reg, iorder_reg};

    for (genvar i = 0; i < INSTANCE_DEPTH; i++) begin : g_icell
        logic pl;
        logic [KW-1:0] ph, pb;
        logic [ID_W-1:0] pd;
        if (i == 0) begin : g_first
            assign pl = 1'b1;
            assign ph = '0;
            assign pb = '0;
            assign pd = '0;
        end else begin : g_rest
            assign pl = icmp[i-1].less;
            assign ph = ihi[i-1];
            assign pb = ilo[i-1];
            assign pd = idat[i-1];
        end
        srkr_cell #(.HI_W(KW), .LO_W(KW), .DATA_W(ID_W)) u_cell (
            .aclk(aclk), .valid(IFL_W'(i) < ifill_reg), .insert(ins_i),
            .prev_less(pl), .prev_hi(ph), .prev_lo(pb), .prev_data(pd),
            .key_hi(tkey_reg), .key_lo(ikey_reg), .new_data(inew),
            .hi(ihi[i]), .lo(ilo[i]), .data(idat[i]), .cmp(icmp[i])
        );
    end

    // slot encode and hit select, over independent cells
    logic [TIX_W-1:0] tpos;
    logic [IIX_W-1:0] ipos;
    logic [TD_W-1:0]  tsel;
    logic [ID_W-1:0]  isel;
    logic             thit, ihit;
    logic [TYPE_DEPTH-1:0]     tbound_vec;
    logic [INSTANCE_DEPTH-1:0] ibound_vec;

    always_comb begin
        tpos = '0;
        tsel = '0;
        thit = 1'b0;
        for (int i = 0; i < TYPE_DEPTH; i++) begin
            tbound_vec[i] = tcmp[i].bound;
            if (tcmp[i].bound) tpos = tpos | TIX_W'(i);
            tsel = tsel | (tdat[i] & {TD_W{tcmp[i].hit}});
            thit = thit | tcmp[i].hit;
        end
        ipos = '0;
        isel = '0;
        ihit = 1'b0;
        for (int i = 0; i < INSTANCE_DEPTH; i++) begin
            ibound_vec[i] = icmp[i].bound;
            if (icmp[i].bound) ipos = ipos | IIX_W'(i);
            isel = isel | (idat[i] & {ID_W{icmp[i].hit}});
            ihit = ihit | icmp[i].hit;
        end
    end

    always_comb begin
        st_next = ST_OK;
        found_next = 1'b0;
        pos_next = '0;
        fnode_next = '0;
        fedge_next = '0;
        freb_next = 1'b0;
        ford_next = '0;
        fgraph_next = '0;
        fctx_next = '0;
        ins_t = 1'b0;
        ins_i = 1'b0;
        unique case (op_reg)
            OP_ADD_TYPE: begin
                if (tkey_reg == '0) begin
                    st_next = ST_ZERO_ID;
                end else if (thit) begin
                    st_next = ST_PRESENT;
                    pos_next = POS_W'(tpos);
                end else if (tfill_reg >= TFL_W'(TYPE_DEPTH)) begin
                    st_next = ST_FULL;
                end else begin
                    ins_t = exec;
                    pos_next = POS_W'(tpos);
                end
            end
            OP_ADD_INST: begin
                if (tkey_reg == '0 || ikey_reg == '0) begin
                    st_next = ST_ZERO_ID;
                end else if (!thit) begin
                    st_next = ST_NO_TYPE;
                end else if (ihit) begin
                    st_next = ST_PRESENT;
                    pos_next = POS_W'(ipos);
                end else if (ifill_reg >= IFL_W'(INSTANCE_DEPTH)) begin
                    st_next = ST_FULL;
                end else begin
                    ins_i = exec;
                    pos_next = POS_W'(ipos);
                end
            end
            OP_FIND_TYPE: begin
                if (thit) begin
                    found_next = 1'b1;
                    pos_next = POS_W'(tpos);
                    {fnode_next, fedge_next, freb_next} = tsel[TD_W-1:TIX_W];
                    ford_next = ORDER_W'(tsel[TIX_W-1:0]);
                end
            end
            OP_FIND_INST: begin
                if (ihit) begin
                    found_next = 1'b1;
                    pos_next = POS_W'(ipos);
                    {fgraph_next, fctx_next} = isel[ID_W-1:IIX_W];
                    ford_next = ORDER_W'(isel[IIX_W-1:0]);
                end
            end
            default: ;
        endcase
        tfill_next = tfill_reg + TFL_W'(ins_t);
        ifill_next = ifill_reg + IFL_W'(ins_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            tfill_reg <= '0;
            ifill_reg <= '0;
            torder_reg <= '0;
            iorder_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
            end else if (exec) begin
                busy_reg <= 1'b0;
            end
            if (exec) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            tfill_reg <= tfill_next;
            ifill_reg <= ifill_next;
            if (ins_t) torder_reg <= torder_reg + 1'b1;
            if (ins_i) iorder_reg <= iorder_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser;
            tkey_reg  <= s_tdata[KW-1:0];
            ikey_reg  <= s_tdata[2*KW-1:KW];
            node_reg  <= s_tdata[2*KW+SCHEMA_W-1:2*KW];
            edge_reg  <= s_tdata[2*KW+2*SCHEMA_W-1:2*KW+SCHEMA_W];
            reb_reg   <= s_tdata[2*KW+2*SCHEMA_W];
            graph_reg <= s_tdata[2*KW+2*SCHEMA_W+HW:2*KW+2*SCHEMA_W+1];
            ctx_reg   <= s_tdata[2*KW+2*SCHEMA_W+2*HW:2*KW+2*SCHEMA_W+HW+1];
        end
        if (exec) begin
            st_reg     <= st_next;
            found_reg  <= found_next;
            pos_reg    <= pos_next;
            fnode_reg  <= fnode_next;
            fedge_reg  <= fedge_next;
            freb_reg   <= freb_next;
            ford_reg   <= ford_next;
            fgraph_reg <= fgraph_next;
            fctx_reg   <= fctx_next;
        end
    end

    logic [TCNT_W-1:0] types_held;
    logic [ICNT_W-1:0] insts_held;
    assign types_held = TCNT_W'(tfill_reg);
    assign insts_held = ICNT_W'(ifill_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = st_reg;
    assign m_tdata  = {{(OUT_W-OUT_RAW){1'b0}}, insts_held, types_held, fctx_reg, fgraph_reg,
                       ford_reg, freb_reg, fedge_reg, fnode_reg, pos_reg, found_reg};

`include "sorted_two_level_key_registry_defines.svh"
    `SRKR_ASSERT(a_tbound_one, $onehot0(tbound_vec), "type chain has several bound slots")
    `SRKR_ASSERT(a_ibound_one, $onehot0(ibound_vec), "instance chain has several bound slots")
    `SRKR_ASSERT(a_tfill_max, tfill_reg <= TFL_W'(TYPE_DEPTH), "type fill beyond depth")
    `SRKR_ASSERT_IMP(a_ins_ok, ins_t || ins_i, exec && st_next == ST_OK, "insert without ok")
    `SRKR_ASSERT_IMP(a_ins_type, ins_i, thit, "instance inserted without its type")
endmodule
